[hw/rtl/event_ring_deque_with_drop_count_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the event ring
// Shared wrappers for concurrent checks on clk / arst_n.
// ----------------------------------------------------------------------------
`ifndef EVENT_RING_DEQUE_WITH_DROP_COUNT_DEFINES_SVH
`define EVENT_RING_DEQUE_WITH_DROP_COUNT_DEFINES_SVH

// same-cycle implication
`define ERDQ_CHECK(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("erdq check failed");

// next-cycle implication
`define ERDQ_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("erdq next-cycle check failed");

`endif

[hw/rtl/erdq_pkg.sv]
// ----------------------------------------------------------------------------
// erdq_pkg
// Types and sizes shared by the event ring modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package erdq_pkg;

	localparam int RING_DEPTH = 1024;
	localparam int EVENT_BITS = 64;
	localparam int PTR_BITS   = $clog2(RING_DEPTH);
	localparam int CNT_BITS   = $clog2(RING_DEPTH + 1);

	localparam int WORD_W     = 64;
	localparam int FILL_W     = 11;
	localparam int DROP_W     = 32;
	localparam int REQ_W      = 2;
	localparam int M_DATA_W   = 112;
	localparam int M_PAD_W    = M_DATA_W - WORD_W - FILL_W - DROP_W;

	typedef logic [PTR_BITS-1:0]   ptr_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;
	typedef logic [EVENT_BITS-1:0] event_t;
	typedef logic [DROP_W-1:0]     drop_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_WRITE      = 2'd0,
		REQ_POP_OLD    = 2'd1,
		REQ_POP_NEW    = 2'd2,
		REQ_CLEAR_DROP = 2'd3
	} req_t;

	typedef struct packed {
		logic  hit;
		cnt_t  fill;
		drop_t drop;
	} stat_t;

endpackage

[hw/rtl/event_ring_deque_with_drop_count.sv]
// ----------------------------------------------------------------------------
// event_ring_deque_with_drop_count
// Event ring with overwrite-oldest writes, pops at both ends and drop count.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries requests: s_tuser = request kind (0 write, 1 pop oldest,
//   2 pop newest, 3 clear drop count), s_tdata = event word for writes.
//   m_* carries one result per request: read word, valid flag, fill count
//   and saturating drop count after that request.
//   From request accept, a result passes through the synchronous ring read
//   and then the output register before it appears on m_*.
//   Throughput is one request per cycle while m_tready stays high; the single ring memory port takes
//   one read or one write per request, and request N+1 sees the write of
//   request N since the accesses fall in separate cycles.
//   When m_tready is low the result waits in the output register while one
//   more request is taken into the read stage; then s_tready drops.
//   Reset clears pointers, counts and the drop counter; the ring contents
//   are not cleared, no entry is read before it is written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "event_ring_deque_with_drop_count_defines.svh"

module event_ring_deque_with_drop_count
	import erdq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [WORD_W-1:0]   s_tdata,  // event_word[63:0]
	input  logic [REQ_W-1:0]    s_tuser,  // req_type[1:0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // read_word[63:0], fill_count[74:64],
	                                      // drop_count[106:75], zero pad
	output logic                m_tuser   // read_valid[0]
);

	logic   accept, advance;
	logic   valid_s1;
	event_t rd_word;
	stat_t  stat;

	logic                m_valid_q;
	logic [M_DATA_W-1:0] m_data_q;
	logic                m_user_q;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	erdq_ring u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_en   (accept),
		.req_type (req_t'(s_tuser)),
		.req_word (s_tdata[EVENT_BITS-1:0]),
		.rd_word  (rd_word),
		.stat     (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= {{M_PAD_W{1'b0}}, stat.drop, FILL_W'(stat.fill),
				(stat.hit ? WORD_W'(rd_word) : {WORD_W{1'b0}})};
			m_user_q <= stat.hit;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	`ERDQ_CHECK_NEXT(a_s1_hold, valid_s1 && m_valid_q && !m_tready, valid_s1 && m_valid_q)
	`ERDQ_CHECK(a_no_overrun, accept, !valid_s1 || advance)
	`ERDQ_CHECK_NEXT(a_out_load, advance, m_valid_q)

endmodule

[hw/rtl/erdq_ring.sv]
// ----------------------------------------------------------------------------
// erdq_ring
// Ring storage, head/tail pointers, fill and drop counters. One request per
// cycle; read data and status are registered and valid the cycle after.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "event_ring_deque_with_drop_count_defines.svh"

module erdq_ring
	import erdq_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   req_en,
	input  req_t   req_type,
	input  event_t req_word,
	output event_t rd_word,
	output stat_t  stat
);

	event_t mem [RING_DEPTH];
	event_t rd_q;
	stat_t  stat_q;

	ptr_t  wr_q, wr_n;
	ptr_t  old_q, old_n;
	cnt_t  cnt_q, cnt_n;
	drop_t drop_q, drop_n;

	logic  mem_we, mem_re, hit;
	ptr_t  addr;
	logic  full, empty;

	function automatic ptr_t ptr_next(ptr_t p);
		return (p == ptr_t'(RING_DEPTH - 1)) ? '0 : p + ptr_t'(1);
	endfunction

	function automatic ptr_t ptr_prev(ptr_t p);
		return (p == '0) ? ptr_t'(RING_DEPTH - 1) : p - ptr_t'(1);
	endfunction

	assign full  = (cnt_q == cnt_t'(RING_DEPTH));
	assign empty = (cnt_q == '0);

	always_comb begin
		wr_n   = wr_q;
		old_n  = old_q;
		cnt_n  = cnt_q;
		drop_n = drop_q;
		mem_we = 1'b0;
		mem_re = 1'b0;
		hit    = 1'b0;
		addr   = wr_q;
		if (req_en) begin
			case (req_type)
				REQ_WRITE: begin
					mem_we = 1'b1;
					addr   = wr_q;
					wr_n   = ptr_next(wr_q);
					if (full) begin
						old_n = ptr_next(old_q);
						if (drop_q != '1) begin
							drop_n = drop_q + drop_t'(1);
						end
					end else begin
						cnt_n = cnt_q + cnt_t'(1);
					end
				end
				REQ_POP_OLD: begin
					if (!empty) begin
						mem_re = 1'b1;
						hit    = 1'b1;
						addr   = old_q;
						old_n  = ptr_next(old_q);
						cnt_n  = cnt_q - cnt_t'(1);
					end
				end
				REQ_POP_NEW: begin
					if (!empty) begin
						mem_re = 1'b1;
						hit    = 1'b1;
						addr   = ptr_prev(wr_q);
						wr_n   = ptr_prev(wr_q);
						cnt_n  = cnt_q - cnt_t'(1);
					end
				end
				REQ_CLEAR_DROP: begin
					drop_n = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			old_q  <= '0;
			cnt_q  <= '0;
			drop_q <= '0;
			stat_q <= '0;
		end else begin
			wr_q   <= wr_n;
			old_q  <= old_n;
			cnt_q  <= cnt_n;
			drop_q <= drop_n;
			if (req_en) begin
				stat_q.hit  <= hit;
				stat_q.fill <= cnt_n;
				stat_q.drop <= drop_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= req_word;
		end
		if (mem_re) begin
			rd_q <= mem[addr];
		end
	end

	assign rd_word = rd_q;
	assign stat    = stat_q;

	`ERDQ_CHECK(a_cnt_range, 1'b1, cnt_q <= cnt_t'(RING_DEPTH))
	`ERDQ_CHECK(a_ptr_meet, empty || full, wr_q == old_q)
	`ERDQ_CHECK_NEXT(a_drop_step, req_en && req_type == REQ_WRITE && full && drop_q != '1,
		drop_q == $past(drop_q) + drop_t'(1))

endmodule
